// File: rtl/mcg_pkg.sv
`default_nettype none

package mcg_pkg;

   localparam int MAX_LEN = 64;
   localparam int MAX_SET = 256;

   localparam int POS_W    = $clog2(MAX_LEN);
   localparam int SLOT_W   = $clog2(MAX_SET);
   localparam int TAB_AW   = POS_W + SLOT_W;
   localparam int SIZE_W   = 9;
   localparam int CHAR_W   = 8;
   localparam int IDX_W    = 64;
   localparam int LEN_W    = 7;
   localparam int OPC_W    = 2;

   localparam int DIV_STEPS  = 8;
   localparam int DIV_CYCLES = IDX_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   typedef enum logic [OPC_W-1:0] {
      OP_WRITE_CHAR = 2'd0,
      OP_SET_SIZE   = 2'd1,
      OP_GENERATE   = 2'd2,
      OP_COUNT      = 2'd3
   } mcg_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_TAB,
      ST_EMIT,
      ST_CNT_MUL,
      ST_CNT_RD,
      ST_CNT_EMIT
   } mcg_state_type;

   typedef struct packed {
      logic wr_char;
      logic wr_size;
      logic load;
      logic div_step;
      logic tab_read;
      logic emit_char;
      logic cnt_mul;
      logic cnt_read;
      logic emit_cnt;
   } mcg_cmd_type;

   typedef struct packed {
      logic last_pos;
      logic out_free;
   } mcg_stat_type;

endpackage

`default_nettype wire

// File: rtl/mcg_ctrl.sv
`default_nettype none

module mcg_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [1:0]                req_opcode,
   input  mcg_pkg::mcg_stat_type     stat,
   output mcg_pkg::mcg_cmd_type      cmd
);
   import mcg_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   mcg_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   mcg_op_type             opcode;

   assign opcode = mcg_op_type'(req_opcode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (opcode)
                  OP_GENERATE:                state_in = ST_DIV;
                  OP_COUNT:                   state_in = ST_CNT_MUL;
                  OP_WRITE_CHAR, OP_SET_SIZE: state_in = ST_IDLE;
                  default:                    state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) state_in = ST_TAB;
         end
         ST_TAB:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) state_in = stat.last_pos ? ST_IDLE : ST_DIV;
         end
         ST_CNT_MUL: state_in = stat.last_pos ? ST_CNT_EMIT : ST_CNT_RD;
         ST_CNT_RD:  state_in = ST_CNT_MUL;
         ST_CNT_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_cnt_in = '0;
      if (state_ff == ST_DIV) div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (opcode)
                  OP_WRITE_CHAR:         cmd.wr_char = 1'b1;
                  OP_SET_SIZE:           cmd.wr_size = 1'b1;
                  OP_GENERATE, OP_COUNT: cmd.load    = 1'b1;
                  default:               cmd         = '0;
               endcase
            end
         end
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_TAB:      cmd.tab_read  = 1'b1;
         ST_EMIT:     cmd.emit_char = stat.out_free;
         ST_CNT_MUL:  cmd.cnt_mul   = 1'b1;
         ST_CNT_RD:   cmd.cnt_read  = 1'b1;
         ST_CNT_EMIT: cmd.emit_cnt  = stat.out_free;
         default:     cmd           = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/mcg_datapath.sv
`default_nettype none

module mcg_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  mcg_pkg::mcg_cmd_type           cmd,
   input  wire  [mcg_pkg::POS_W-1:0]      position,
   input  wire  [mcg_pkg::SLOT_W-1:0]     slot,
   input  wire  [mcg_pkg::CHAR_W-1:0]     char_value,
   input  wire  [mcg_pkg::SIZE_W-1:0]     set_size,
   input  wire  [mcg_pkg::IDX_W-1:0]      cand_index,
   input  wire  [mcg_pkg::POS_W-1:0]      last_idx,
   output mcg_pkg::mcg_stat_type          stat,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [mcg_pkg::CHAR_W-1:0]     out_char,
   output logic                           out_last,
   output logic [mcg_pkg::IDX_W-1:0]      cand_count
);
   import mcg_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SET);

   logic [CHAR_W-1:0] char_mem [0:(1 << TAB_AW)-1];
   logic [SIZE_W-1:0] size_mem [0:MAX_LEN-1];
   logic [MAX_LEN-1:0] size_vld_ff;

   logic [CHAR_W-1:0] tab_rd_ff;
   logic [SIZE_W-1:0] size_rd_ff;
   logic              size_ok_ff;
   logic [SIZE_W-1:0] size_eff;
   logic [SIZE_W-1:0] size_wr;
   logic [POS_W-1:0]  size_addr;
   logic              size_rd_en;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  quo_ff, quo_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]  prod_ff, prod_in;
   logic [IDX_W-1:0]  prod_mul;
   logic [IDX_W-1:0]  quo_step;
   logic [SLOT_W-1:0] rem_step;

   logic              vld_ff, vld_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      size_wr = set_size;
      if (set_size == '0) size_wr = SIZE_ONE;
      else if (set_size > SIZE_MAX) size_wr = SIZE_MAX;
   end

   always_comb begin
      size_addr  = pos_ff;
      size_rd_en = cmd.load | cmd.tab_read | cmd.cnt_read;
      if (cmd.load) size_addr = '0;
      else if (cmd.tab_read) size_addr = pos_ff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_char) char_mem[{position, slot}] <= char_value;
      if (cmd.tab_read) tab_rd_ff <= char_mem[{pos_ff, rem_ff}];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_size) size_mem[position] <= size_wr;
      if (size_rd_en) size_rd_ff <= size_mem[size_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_vld_ff <= '0;
         size_ok_ff  <= 1'b0;
      end else begin
         if (cmd.wr_size) size_vld_ff[position] <= 1'b1;
         if (size_rd_en) size_ok_ff <= size_vld_ff[size_addr];
      end
   end

   assign size_eff = size_ok_ff ? size_rd_ff : SIZE_ONE;

   always_comb begin
      logic [IDX_W-1:0]  q;
      logic [SLOT_W-1:0] r;
      logic [SIZE_W-1:0] t;
      logic [SIZE_W-1:0] d;
      logic              ge;
      q = quo_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t  = {r, q[IDX_W-1]};
         ge = (t >= size_eff);
         d  = t - size_eff;
         q  = {q[IDX_W-2:0], ge};
         r  = ge ? d[SLOT_W-1:0] : t[SLOT_W-1:0];
      end
      quo_step = q;
      rem_step = r;
   end

   assign prod_mul = prod_ff * IDX_W'(size_eff);

   always_comb begin
      pos_in  = pos_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         pos_in  = '0;
         quo_in  = cand_index;
         rem_in  = '0;
         prod_in = IDX_W'(1);
      end
      if (cmd.div_step) begin
         quo_in = quo_step;
         rem_in = rem_step;
      end
      if (cmd.emit_char) begin
         rem_in = '0;
         pos_in = pos_ff + POS_W'(1);
      end
      if (cmd.cnt_mul) begin
         prod_in = prod_mul;
         pos_in  = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
   end

   assign stat.last_pos = (pos_ff == last_idx);
   assign stat.out_free = ~vld_ff | rsp_tready;

   always_comb begin
      vld_in  = vld_ff & ~rsp_tready;
      char_in = char_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      if (cmd.emit_char) begin
         vld_in  = 1'b1;
         char_in = tab_rd_ff;
         last_in = stat.last_pos;
         cnt_in  = '0;
      end else if (cmd.emit_cnt) begin
         vld_in  = 1'b1;
         char_in = '0;
         last_in = 1'b1;
         cnt_in  = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp_tvalid = vld_ff;
   assign out_char   = char_ff;
   assign out_last   = last_ff;
   assign cand_count = cnt_ff;

endmodule

`default_nettype wire

// File: rtl/mask_candidate_generator.sv
`default_nettype none
// Channel  Direction  Handshake             Word
// req_     in         tvalid/tready         tuser opcode, tdata fields, one command
// rsp_     out        tvalid/tready/tlast   tdata out_char and cand_count, tlast last
// csr_     in         APB, pready tied high password_length at byte address 0
//
// Table write and size set: each is taken in the idle state, which it does not leave.
// Generate: per position, 8 radix-2 divider passes of 8 bits, one table read and one
// output load; each position gives one character word, the last one with tlast.
// Count query: per position a multiply through the 64 x 9 multiplier and, but for the last, a size read.
// Reset clears control state, sizes read as 1 until set; table is undefined until written.
// A stalled result holds in the output register; generation waits on it.

module mask_candidate_generator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] opcode
   input  wire  [1:0]  req_tuser,
   // [5:0] position, [13:6] slot, [21:14] char_value, [30:22] set_size,
   // [94:31] cand_index, [95] zero
   input  wire  [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic        rsp_tlast,
   // [7:0] out_char, [71:8] cand_count
   output logic [71:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mcg_pkg::*;

   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);

   logic [LEN_W-1:0] pw_len_ff, pw_len_in;
   logic [POS_W-1:0] last_idx;
   logic             csr_wr;

   mcg_cmd_type      cmd;
   mcg_stat_type     stat;

   logic [CHAR_W-1:0] out_char;
   logic [IDX_W-1:0]  cand_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready & ~csr_paddr[2];

   always_comb begin
      pw_len_in = pw_len_ff;
      if (csr_wr) pw_len_in = csr_pwdata[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) pw_len_ff <= LEN_W'(1);
      else pw_len_ff <= pw_len_in;
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32 - LEN_W){1'b0}}, pw_len_ff};

   always_comb begin
      logic [LEN_W-1:0] m1;
      m1 = pw_len_ff - LEN_W'(1);
      if (pw_len_ff == '0) last_idx = '0;
      else if (pw_len_ff > LEN_LIMIT) last_idx = POS_W'(MAX_LEN - 1);
      else last_idx = m1[POS_W-1:0];
   end

   mcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   mcg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .position   (req_tdata[5:0]),
      .slot       (req_tdata[13:6]),
      .char_value (req_tdata[21:14]),
      .set_size   (req_tdata[30:22]),
      .cand_index (req_tdata[94:31]),
      .last_idx   (last_idx),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_char   (out_char),
      .out_last   (rsp_tlast),
      .cand_count (cand_count)
   );

   assign rsp_tdata = {cand_count, out_char};

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_char || cmd.emit_cnt) |-> stat.out_free)
      else $error("result loaded over a waiting word");

   a_gen_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_GENERATE) |=> !req_tready)
      else $error("generate did not hold off the next word");

   a_count_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[71:8] != 64'd0) |-> (rsp_tlast && rsp_tdata[7:0] == 8'd0))
      else $error("count word without last or with a character");

endmodule

`default_nettype wire

// File: sim/mcg_checker.sv
module mcg_checker
   import mcg_pkg::*;
#(
   parameter logic [2:0] LENGTH_ADDR = 3'd0
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   // [1:0] opcode
   input  wire  [1:0]  req_tuser,
   // [5:0] position, [13:6] slot, [21:14] char_value, [30:22] set_size,
   // [94:31] cand_index, [95] zero
   input  wire  [95:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         rsp_tlast,
   // [7:0] out_char, [71:8] cand_count
   input  wire  [71:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   input  wire  [31:0] csr_prdata,
   input  wire         csr_pready,
   output int          mismatches,
   output int          words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic [63:0] cnt;
   } mcg_word_type;

   mcg_word_type  due_words [$];
   logic [7:0]    charset_copy [MAX_LEN*MAX_SET];
   logic [8:0]    size_copy [MAX_LEN];
   logic [6:0]    length_copy;
   int            fault_total;

   task automatic report_fault(input string what, input mcg_word_type want,
                               input mcg_word_type got);
      if (fault_total < 10) begin
         $display("%0t: %s: expected char %h last %b count %h, got char %h last %b count %h",
                  $realtime, what, want.ch, want.last, want.cnt, got.ch, got.last, got.cnt);
      end
      fault_total++;
   endtask

   task automatic decode_command(input mcg_op_type op, input logic [95:0] fields);
      logic [5:0]   pos;
      logic [7:0]   slot;
      logic [7:0]   ch;
      logic [8:0]   size;
      logic [63:0]  rest;
      logic [63:0]  radix;
      logic [63:0]  digit;
      logic [63:0]  prod;
      int unsigned  span;
      mcg_word_type w;
      pos  = fields[5:0];
      slot = fields[13:6];
      ch   = fields[21:14];
      size = fields[30:22];
      rest = fields[94:31];
      span = length_copy;
      if (span < 1) span = 1;
      if (span > MAX_LEN) span = MAX_LEN;
      if (span > 64) span = 64;
      case (op)
         OP_WRITE_CHAR: begin
            if (pos < MAX_LEN && slot < MAX_SET) charset_copy[pos*MAX_SET + slot] = ch;
         end
         OP_SET_SIZE: begin
            if (pos < MAX_LEN) begin
               if (size < 1) size = 9'd1;
               if (size > MAX_SET) size = 9'(MAX_SET);
               size_copy[pos] = size;
            end
         end
         OP_GENERATE: begin
            for (int p = 0; p < span; p++) begin
               radix = {55'd0, size_copy[p]};
               if (radix == 0) radix = 64'd1;
               digit = rest % radix;
               rest = rest / radix;
               w.ch = charset_copy[p*MAX_SET + int'(digit)];
               w.last = (p + 1 == span);
               w.cnt = '0;
               due_words.push_back(w);
            end
         end
         default: begin
            prod = 64'd1;
            for (int p = 0; p < span; p++) prod = prod * {55'd0, size_copy[p]};
            w.ch = '0;
            w.last = 1'b1;
            w.cnt = prod;
            due_words.push_back(w);
         end
      endcase
   endtask

   always @(posedge clock) begin
      mcg_word_type got;
      mcg_word_type want;
      if (reset) begin
         due_words.delete();
         for (int p = 0; p < MAX_LEN; p++) size_copy[p] = 9'd1;
         length_copy = 7'd1;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LENGTH_ADDR) begin
            if (csr_pwrite) begin
               length_copy = csr_pwdata[6:0];
            end else if (csr_prdata != {25'd0, length_copy}) begin
               if (fault_total < 10) begin
                  $display("%0t: length read back: expected %h, got %h",
                           $realtime, {25'd0, length_copy}, csr_prdata);
               end
               fault_total++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ch = rsp_tdata[7:0];
            got.last = rsp_tlast;
            got.cnt = rsp_tdata[71:8];
            if (due_words.size() == 0) begin
               report_fault("unexpected word", '0, got);
            end else begin
               want = due_words.pop_front();
               if (got !== want) report_fault("word mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) decode_command(mcg_op_type'(req_tuser), req_tdata);
      end
      words_due <= due_words.size();
      mismatches <= fault_total;
   end

endmodule

// File: sim/tb_mask_candidate_generator.sv
module tb_mask_candidate_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import mcg_pkg::*;

   localparam logic [2:0] LENGTH_ADDR = 3'd0;
   localparam int RANDOM_PER_PHASE = 42;
   localparam int PHASES = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES = 700;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tlast;
   logic [71:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatches;
   int          words_due;

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          cycle_count = 0;
   int          sent_words = 0;
   bit          tab_written [MAX_LEN*MAX_SET];
   int unsigned held_size [MAX_LEN];
   int unsigned held_span = 1;

   mask_candidate_generator dut (.*);

   mcg_checker #(.LENGTH_ADDR(LENGTH_ADDR)) candidate_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   task automatic send_word(input mcg_op_type op, input logic [5:0] pos,
                            input logic [7:0] slot, input logic [7:0] ch,
                            input logic [8:0] size, input logic [63:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, idx, size, ch, slot, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_words++;
      if (op == OP_WRITE_CHAR) tab_written[pos*MAX_SET + slot] = 1'b1;
      if (op == OP_SET_SIZE) begin
         held_size[pos] = (size == 0) ? 1 : (size > MAX_SET) ? MAX_SET : size;
      end
   endtask

   task automatic fill_active_sets(input logic [63:0] idx);
      logic [63:0] rest;
      int unsigned digit;
      rest = idx;
      for (int p = 0; p < held_span; p++) begin
         digit = 32'(rest % 64'(held_size[p]));
         rest = rest / 64'(held_size[p]);
         if (!tab_written[p*MAX_SET + digit]) begin
            send_word(OP_WRITE_CHAR, 6'(p), 8'(digit), 8'($urandom), 9'($urandom),
                      {$urandom, $urandom});
         end
      end
   endtask

   task automatic settle(input int cycles);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [6:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_length(input logic [6:0] value);
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      held_span = (value == 0) ? 1 : (value > MAX_LEN) ? MAX_LEN : value;
   endtask

   task automatic random_command();
      int          pick;
      logic [5:0]  pos;
      logic [8:0]  size;
      logic [63:0] idx;
      pick = $urandom_range(99);
      pos = ($urandom_range(1) != 0) ? 6'($urandom_range(held_span - 1)) : 6'($urandom);
      case ($urandom_range(9))
         0: size = 9'd0;
         1: size = 9'($urandom_range(MAX_SET + 1, 511));
         2: size = 9'($urandom_range(1, MAX_SET));
         default: size = 9'($urandom_range(1, 6));
      endcase
      case ($urandom_range(3))
         2: idx = 64'($urandom_range(1000));
         3: idx = ($urandom_range(1) != 0) ? '1 : '0;
         default: idx = {$urandom, $urandom};
      endcase
      if (pick < 20) begin
         send_word(OP_WRITE_CHAR, pos, 8'($urandom), 8'($urandom), size, idx);
      end else if (pick < 40) begin
         send_word(OP_SET_SIZE, pos, 8'($urandom), 8'($urandom), size, idx);
      end else if (pick < 80) begin
         fill_active_sets(idx);
         send_word(OP_GENERATE, pos, 8'($urandom), 8'($urandom), size, idx);
      end else begin
         send_word(OP_COUNT, pos, 8'($urandom), 8'($urandom), size, idx);
      end
   endtask

   initial begin
      for (int p = 0; p < MAX_LEN; p++) held_size[p] = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         if (phase != 0) settle(SETTLE_CYCLES);
         case (phase)
            0: begin
               csr_access(1'b0, '0);
               send_word(OP_COUNT, 6'd5, 8'd7, 8'd9, 9'd3, 64'd11);
               send_word(OP_WRITE_CHAR, 6'd0, 8'd0, 8'hFF, 9'd0, '0);
               send_word(OP_WRITE_CHAR, 6'd63, 8'd255, 8'h00, 9'h1FF, '1);
               send_word(OP_GENERATE, 6'd0, 8'd0, 8'd0, 9'd0, 64'd0);
               send_word(OP_GENERATE, 6'd63, 8'hFF, 8'hFF, 9'h1FF, '1);
               send_word(OP_SET_SIZE, 6'd0, 8'd0, 8'd0, 9'd0, '0);
               send_word(OP_COUNT, 6'd0, 8'd0, 8'd0, 9'd0, '0);
               send_word(OP_WRITE_CHAR, 6'd0, 8'd1, 8'h5A, 9'd0, '0);
               send_word(OP_SET_SIZE, 6'd0, 8'd0, 8'd0, 9'd2, '0);
               send_word(OP_GENERATE, 6'd0, 8'd0, 8'd0, 9'd0, '1);
               send_word(OP_GENERATE, 6'd0, 8'd0, 8'd0, 9'd0, 64'd2);
               send_word(OP_SET_SIZE, 6'd63, 8'd0, 8'd0, 9'h1FF, '0);
               send_word(OP_SET_SIZE, 6'd62, 8'd0, 8'd0, 9'd257, '0);
               send_word(OP_SET_SIZE, 6'd1, 8'd0, 8'd0, 9'd256, '0);
               send_word(OP_COUNT, 6'd0, 8'd0, 8'd0, 9'd0, '0);
            end
            1: set_length(7'd64);
            2: set_length(7'd0);
            3: set_length(7'd127);
            4: set_length(7'($urandom_range(2, 63)));
            default: set_length(7'($urandom_range(65, 126)));
         endcase
         while (sent_words < (phase + 1) * RANDOM_PER_PHASE) random_command();
      end
      settle(DRAIN_CYCLES);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
